[design/ccc_pkg.sv]
package ccc_pkg;

    localparam int PIX_W   = 8;
    localparam int CODE_W  = 3;
    localparam int K_W     = 11;
    localparam int NUM_W   = 17;
    localparam int DEN_W   = 9;
    localparam int HUE_W   = 8;

    localparam int DIV_STAGES         = 4;
    localparam int DIV_BITS_PER_STAGE = HUE_W / DIV_STAGES;

    localparam logic [PIX_W-1:0] WHITE_MIN    = 8'd200;
    localparam logic [PIX_W-1:0] WHITE_SPREAD = 8'd30;

    localparam logic [HUE_W-1:0] RED_LO    = 8'd160;
    localparam logic [HUE_W-1:0] RED_HI    = 8'd190;
    localparam logic [HUE_W-1:0] ORANGE_LO = 8'd3;
    localparam logic [HUE_W-1:0] ORANGE_HI = 8'd19;
    localparam logic [HUE_W-1:0] YELLOW_LO = 8'd20;
    localparam logic [HUE_W-1:0] YELLOW_HI = 8'd30;
    localparam logic [HUE_W-1:0] GREEN_LO  = 8'd60;
    localparam logic [HUE_W-1:0] GREEN_HI  = 8'd90;
    localparam logic [HUE_W-1:0] BLUE_LO   = 8'd100;
    localparam logic [HUE_W-1:0] BLUE_HI   = 8'd120;

    localparam logic [CODE_W-1:0] CODE_WHITE  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_RED    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ORANGE = 3'd2;
    localparam logic [CODE_W-1:0] CODE_YELLOW = 3'd3;
    localparam logic [CODE_W-1:0] CODE_GREEN  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_BLUE   = 3'd5;

    // Dividend, divisor and white override handed to the hue divider
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             white;
    } div_req_t;

    // Quotient (hue in half degrees) and white override out of the divider
    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             white;
    } div_res_t;

endpackage

[design/ccc_if.sv]
interface ccc_pix_if;
    logic                     valid;
    logic                     ready;
    logic [ccc_pkg::PIX_W-1:0] blue;
    logic [ccc_pkg::PIX_W-1:0] green;
    logic [ccc_pkg::PIX_W-1:0] red;

    modport source (output valid, output blue, output green, output red, input ready);
    modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface ccc_code_if;
    logic                      valid;
    logic                      ready;
    logic [ccc_pkg::CODE_W-1:0] color_code;

    modport source (output valid, output color_code, input ready);
    modport sink   (input valid, input color_code, output ready);
endinterface

[design/classify_cube_color.sv]
// Sticker color classifier for one BGR pixel per word. A pixel whose three
// channels all exceed 200 and differ pairwise by less than 30 is white (0);
// otherwise the HSV hue, in half degrees (0..180) rounded to nearest, picks
// red (160..190), orange (3..19), yellow (20..30), green (60..90) or blue
// (100..120), tested in that order, with white as the fallback; a gray pixel
// has hue 0 and so also reads white. The block takes a new pixel every clock
// unless backpressure holds it, and passes each pixel through its stages:
// three front stages form the channel extremes and the hue dividend and
// divisor, four divider stages settle two quotient bits each, and one stage
// maps the hue to a band into the output register. Backpressure on the
// result channel holds the pipeline; empty stages still fill, so pixels keep
// flowing until every stage holds a word.
module classify_cube_color (
    input  logic        clk,
    input  logic        rst_n,
    ccc_pix_if.sink     pixel,
    ccc_code_if.source  result
);

    logic               req_valid;
    logic               req_ready;
    ccc_pkg::div_req_t  req;
    logic               res_valid;
    logic               res_ready;
    ccc_pkg::div_res_t  res;

    logic                       out_vld_reg;
    logic [ccc_pkg::CODE_W-1:0] code_reg;
    logic [ccc_pkg::CODE_W-1:0] code_next;

    // Extremes, sector offset, dividend and divisor
    ccc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    // Pipelined hue divider
    ccc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Advance the output register when it is empty or being drained
    assign res_ready = !out_vld_reg || result.ready;

    // Band lookup; first match wins
    always_comb
    begin
        if (res.white)
            code_next = ccc_pkg::CODE_WHITE;
        else if (res.hue >= ccc_pkg::RED_LO && res.hue <= ccc_pkg::RED_HI)
            code_next = ccc_pkg::CODE_RED;
        else if (res.hue >= ccc_pkg::ORANGE_LO && res.hue <= ccc_pkg::ORANGE_HI)
            code_next = ccc_pkg::CODE_ORANGE;
        else if (res.hue >= ccc_pkg::YELLOW_LO && res.hue <= ccc_pkg::YELLOW_HI)
            code_next = ccc_pkg::CODE_YELLOW;
        else if (res.hue >= ccc_pkg::GREEN_LO && res.hue <= ccc_pkg::GREEN_HI)
            code_next = ccc_pkg::CODE_GREEN;
        else if (res.hue >= ccc_pkg::BLUE_LO && res.hue <= ccc_pkg::BLUE_HI)
            code_next = ccc_pkg::CODE_BLUE;
        else
            code_next = ccc_pkg::CODE_WHITE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (res_ready)
            out_vld_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            code_reg <= code_next;
    end

    assign result.valid      = out_vld_reg;
    assign result.color_code = code_reg;

endmodule

[design/ccc_front.sv]
module ccc_front (
    input  logic               clk,
    input  logic               rst_n,
    ccc_pix_if.sink            pixel,
    output logic               req_valid,
    input  logic               req_ready,
    output ccc_pkg::div_req_t  req
);

    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    function automatic logic [ccc_pkg::PIX_W-1:0] abs_diff(
        input logic [ccc_pkg::PIX_W-1:0] a,
        input logic [ccc_pkg::PIX_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Stage 1: extremes, max selector, white test
    logic                      s1_vld_reg;
    logic [ccc_pkg::PIX_W-1:0] s1_r_reg, s1_g_reg, s1_b_reg;
    logic [ccc_pkg::PIX_W-1:0] s1_mx_reg, s1_mn_reg;
    logic [1:0]                s1_sel_reg;
    logic                      s1_white_reg;
    logic [ccc_pkg::PIX_W-1:0] s1_mx_next, s1_mn_next;
    logic [1:0]                s1_sel_next;
    logic                      s1_white_next;

    // Stage 2: spread and sector offset
    logic                      s2_vld_reg;
    logic [ccc_pkg::PIX_W-1:0] s2_d_reg;
    logic [ccc_pkg::K_W-1:0]   s2_k_reg;
    logic                      s2_white_reg;
    logic [ccc_pkg::K_W-1:0]   s2_k_next;

    // Stage 3: dividend and divisor
    logic                      s3_vld_reg;
    ccc_pkg::div_req_t         s3_req_reg;
    ccc_pkg::div_req_t         s3_req_next;

    logic rdy1, rdy2, rdy3;

    assign rdy3        = !s3_vld_reg || req_ready;
    assign rdy2        = !s2_vld_reg || rdy3;
    assign rdy1        = !s1_vld_reg || rdy2;
    assign pixel.ready = rdy1;
    assign req_valid   = s3_vld_reg;
    assign req         = s3_req_reg;

    always_comb
    begin
        s1_mx_next = pixel.red;
        s1_mn_next = pixel.red;
        if (pixel.green > s1_mx_next) s1_mx_next = pixel.green;
        if (pixel.blue  > s1_mx_next) s1_mx_next = pixel.blue;
        if (pixel.green < s1_mn_next) s1_mn_next = pixel.green;
        if (pixel.blue  < s1_mn_next) s1_mn_next = pixel.blue;

        if (pixel.red >= pixel.green && pixel.red >= pixel.blue)
            s1_sel_next = SEL_RED;
        else if (pixel.green >= pixel.blue)
            s1_sel_next = SEL_GREEN;
        else
            s1_sel_next = SEL_BLUE;

        s1_white_next = (pixel.red   > ccc_pkg::WHITE_MIN) &&
                        (pixel.green > ccc_pkg::WHITE_MIN) &&
                        (pixel.blue  > ccc_pkg::WHITE_MIN) &&
                        (abs_diff(pixel.red,   pixel.green) < ccc_pkg::WHITE_SPREAD) &&
                        (abs_diff(pixel.green, pixel.blue)  < ccc_pkg::WHITE_SPREAD) &&
                        (abs_diff(pixel.blue,  pixel.red)   < ccc_pkg::WHITE_SPREAD);
    end

    always_comb
    begin
        logic [ccc_pkg::PIX_W-1:0] d;
        logic signed [ccc_pkg::K_W:0] k_wide;
        logic signed [ccc_pkg::K_W:0] r_s, g_s, b_s, d2_s, d4_s, d6_s;

        d    = s1_mx_reg - s1_mn_reg;
        r_s  = $signed({4'b0, s1_r_reg});
        g_s  = $signed({4'b0, s1_g_reg});
        b_s  = $signed({4'b0, s1_b_reg});
        d2_s = $signed({3'b0, d, 1'b0});
        d4_s = $signed({2'b0, d, 2'b0});
        d6_s = d4_s + d2_s;

        case (s1_sel_reg)
            SEL_RED:
            begin
                k_wide = g_s - b_s;
                if (k_wide < 0) k_wide = k_wide + d6_s;
            end
            SEL_GREEN: k_wide = b_s - r_s + d2_s;
            default:   k_wide = r_s - g_s + d4_s;
        endcase
        s2_k_next = k_wide[ccc_pkg::K_W-1:0];
    end

    // 60k + d as 64k - 4k + d
    always_comb
    begin
        s3_req_next.num   = {s2_k_reg, 6'b0}
                          - {4'b0, s2_k_reg, 2'b0}
                          + {9'b0, s2_d_reg};
        s3_req_next.den   = {s2_d_reg, 1'b0};
        s3_req_next.white = s2_white_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) s1_vld_reg <= pixel.valid;
            if (rdy2) s2_vld_reg <= s1_vld_reg;
            if (rdy3) s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && pixel.valid)
        begin
            s1_r_reg     <= pixel.red;
            s1_g_reg     <= pixel.green;
            s1_b_reg     <= pixel.blue;
            s1_mx_reg    <= s1_mx_next;
            s1_mn_reg    <= s1_mn_next;
            s1_sel_reg   <= s1_sel_next;
            s1_white_reg <= s1_white_next;
        end
        if (rdy2 && s1_vld_reg)
        begin
            s2_d_reg     <= s1_mx_reg - s1_mn_reg;
            s2_k_reg     <= s2_k_next;
            // gray pixel: hue is zero, which lands in no band
            s2_white_reg <= s1_white_reg || (s1_mx_reg == s1_mn_reg);
        end
        if (rdy3 && s2_vld_reg)
            s3_req_reg <= s3_req_next;
    end

endmodule

[design/ccc_div.sv]
module ccc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ccc_pkg::div_req_t  req,
    output logic               res_valid,
    input  logic               res_ready,
    output ccc_pkg::div_res_t  res
);

    typedef struct packed {
        logic [ccc_pkg::NUM_W-1:0] rem;
        logic [ccc_pkg::DEN_W-1:0] den;
        logic [ccc_pkg::HUE_W-1:0] quo;
        logic                      white;
    } div_stg_t;

    div_stg_t stg_reg  [ccc_pkg::DIV_STAGES];
    div_stg_t stg_next [ccc_pkg::DIV_STAGES];
    div_stg_t src_stg  [ccc_pkg::DIV_STAGES];
    logic     vld_reg  [ccc_pkg::DIV_STAGES];
    logic     src_vld  [ccc_pkg::DIV_STAGES];
    logic     rdy      [ccc_pkg::DIV_STAGES+1];

    assign rdy[ccc_pkg::DIV_STAGES] = res_ready;
    assign req_ready = rdy[0];
    assign res_valid = vld_reg[ccc_pkg::DIV_STAGES-1];
    assign res.hue   = stg_reg[ccc_pkg::DIV_STAGES-1].quo;
    assign res.white = stg_reg[ccc_pkg::DIV_STAGES-1].white;

    assign src_stg[0].rem   = req.num;
    assign src_stg[0].den   = req.den;
    assign src_stg[0].quo   = '0;
    assign src_stg[0].white = req.white;
    assign src_vld[0]       = req_valid;

    genvar s;
    generate
        for (s = 0; s < ccc_pkg::DIV_STAGES; s++)
        begin : g_stage
            localparam int HI = ccc_pkg::HUE_W - 1 - ccc_pkg::DIV_BITS_PER_STAGE * s;

            if (s > 0)
            begin : g_link
                assign src_stg[s] = stg_reg[s-1];
                assign src_vld[s] = vld_reg[s-1];
            end

            assign rdy[s] = !vld_reg[s] || rdy[s+1];

            // Restoring division, one quotient bit per step
            always_comb
            begin
                logic [ccc_pkg::NUM_W-1:0] den_ext;
                logic [ccc_pkg::NUM_W-1:0] dsh;
                logic [ccc_pkg::NUM_W-1:0] rem_w;
                logic [ccc_pkg::HUE_W-1:0] quo_w;

                den_ext = {{(ccc_pkg::NUM_W-ccc_pkg::DEN_W){1'b0}}, src_stg[s].den};
                rem_w   = src_stg[s].rem;
                quo_w   = src_stg[s].quo;
                for (int j = 0; j < ccc_pkg::DIV_BITS_PER_STAGE; j++)
                begin
                    dsh = den_ext << (HI - j);
                    if (rem_w >= dsh)
                    begin
                        rem_w          = rem_w - dsh;
                        quo_w[HI - j]  = 1'b1;
                    end
                end
                stg_next[s].rem   = rem_w;
                stg_next[s].den   = src_stg[s].den;
                stg_next[s].quo   = quo_w;
                stg_next[s].white = src_stg[s].white;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (rdy[s])
                    vld_reg[s] <= src_vld[s];
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && src_vld[s])
                    stg_reg[s] <= stg_next[s];
            end
        end
    endgenerate

endmodule

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [ccc_pkg::PIX_W-1:0]  pix_t;
    typedef logic [ccc_pkg::CODE_W-1:0] code_t;

    logic clk;
    logic rst_n;

    ccc_pix_if  pix_bus();
    ccc_code_if code_bus();

    classify_cube_color u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_bus),
        .result (code_bus)
    );

    // One row of the directed table. Where known is set, code holds the
    // sticker color read straight off the spec; otherwise the predictor
    // supplies it.
    typedef struct packed {
        pix_t  blue;
        pix_t  green;
        pix_t  red;
        logic  known;
        code_t code;
    } pix_row_t;

    localparam int NUM_ROWS = 20;

    // Directed words: channel extremes, the white window edges, a gray
    // pixel below the white floor, the primaries and secondaries, ties
    // between channels, the red band reaching hue 180, and band edges.
    pix_row_t dir_rows [NUM_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, ccc_pkg::CODE_WHITE},   // black, gray hue 0
        '{8'd255, 8'd255, 8'd255, 1'b1, ccc_pkg::CODE_WHITE},   // full white
        '{8'd201, 8'd201, 8'd201, 1'b1, ccc_pkg::CODE_WHITE},   // just above floor
        '{8'd200, 8'd200, 8'd200, 1'b1, ccc_pkg::CODE_WHITE},   // gray on the floor
        '{8'd0,   8'd0,   8'd255, 1'b1, ccc_pkg::CODE_WHITE},   // pure red, hue 0
        '{8'd0,   8'd255, 8'd0,   1'b1, ccc_pkg::CODE_GREEN},   // pure green
        '{8'd255, 8'd0,   8'd0,   1'b1, ccc_pkg::CODE_BLUE},    // pure blue
        '{8'd0,   8'd255, 8'd255, 1'b1, ccc_pkg::CODE_YELLOW},  // yellow
        '{8'd255, 8'd0,   8'd255, 1'b0, ccc_pkg::CODE_WHITE},   // magenta
        '{8'd255, 8'd255, 8'd0,   1'b0, ccc_pkg::CODE_WHITE},   // cyan
        '{8'd201, 8'd201, 8'd230, 1'b0, ccc_pkg::CODE_WHITE},   // spread 29
        '{8'd201, 8'd201, 8'd231, 1'b0, ccc_pkg::CODE_WHITE},   // spread 30
        '{8'd200, 8'd255, 8'd255, 1'b0, ccc_pkg::CODE_WHITE},   // blue on the floor
        '{8'd0,   8'd128, 8'd255, 1'b0, ccc_pkg::CODE_WHITE},   // orange
        '{8'd80,  8'd0,   8'd255, 1'b0, ccc_pkg::CODE_WHITE},   // deep red band
        '{8'd1,   8'd0,   8'd255, 1'b0, ccc_pkg::CODE_WHITE},   // hue 180
        '{8'd50,  8'd100, 8'd100, 1'b0, ccc_pkg::CODE_WHITE},   // red and green tie
        '{8'd100, 8'd100, 8'd50,  1'b0, ccc_pkg::CODE_WHITE},   // green and blue tie
        '{8'd0,   8'd10,  8'd255, 1'b0, ccc_pkg::CODE_WHITE},   // near orange edge
        '{8'd254, 8'd1,   8'd0,   1'b0, ccc_pkg::CODE_WHITE}    // near blue edge
    };

    typedef enum logic [1:0] {
        RX_FULL,
        RX_COIN,
        RX_SPARSE,
        RX_BEAT
    } rx_mode_t;

    code_t color_queue [$];
    int    fail_count;
    bit    hold_req;
    bit    no_gap;
    int    burst_left;

    // Clock and the run limit
    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2ms;
        $display("FAIL classify_cube_color");
        $finish;
    end

    // Work out the sticker color of one pixel: white window first, then
    // the half-degree hue rounded half up, then the bands in priority order.
    function automatic code_t sticker_color(
        pix_t b,
        pix_t g,
        pix_t r
    );
        int bi;
        int gi;
        int ri;
        int mx;
        int mn;
        int d;
        int k;
        int hue;
        bi = int'(b);
        gi = int'(g);
        ri = int'(r);
        if (ri > ccc_pkg::WHITE_MIN && gi > ccc_pkg::WHITE_MIN &&
            bi > ccc_pkg::WHITE_MIN &&
            (ri > gi ? ri - gi : gi - ri) < ccc_pkg::WHITE_SPREAD &&
            (gi > bi ? gi - bi : bi - gi) < ccc_pkg::WHITE_SPREAD &&
            (bi > ri ? bi - ri : ri - bi) < ccc_pkg::WHITE_SPREAD)
            return ccc_pkg::CODE_WHITE;
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        d = mx - mn;
        if (d == 0)
            hue = 0;
        else
        begin
            // red wins ties, then green
            if (mx == ri)
            begin
                k = gi - bi;
                if (k < 0) k = k + 6 * d;
            end
            else if (mx == gi)
                k = bi - ri + 2 * d;
            else
                k = ri - gi + 4 * d;
            hue = (60 * k + d) / (2 * d);
        end
        if (hue >= ccc_pkg::RED_LO && hue <= ccc_pkg::RED_HI)
            return ccc_pkg::CODE_RED;
        else if (hue >= ccc_pkg::ORANGE_LO && hue <= ccc_pkg::ORANGE_HI)
            return ccc_pkg::CODE_ORANGE;
        else if (hue >= ccc_pkg::YELLOW_LO && hue <= ccc_pkg::YELLOW_HI)
            return ccc_pkg::CODE_YELLOW;
        else if (hue >= ccc_pkg::GREEN_LO && hue <= ccc_pkg::GREEN_HI)
            return ccc_pkg::CODE_GREEN;
        else if (hue >= ccc_pkg::BLUE_LO && hue <= ccc_pkg::BLUE_HI)
            return ccc_pkg::CODE_BLUE;
        return ccc_pkg::CODE_WHITE;
    endfunction

    function automatic pix_t clamp_chan(int v);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return v[ccc_pkg::PIX_W-1:0];
    endfunction

    // Draw one random pixel. Mix uniform pixels with pixels near the white
    // window, grays, channel ties, and max-min spreads, often tight, that probe the
    // hue rounding at the band edges.
    task automatic draw_pixel(output pix_t b,
                              output pix_t g,
                              output pix_t r);
        int pick;
        int base;
        int d;
        int mn;
        int mid;
        int v0;
        int v1;
        int v2;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            b = pix_t'($urandom);
            g = pix_t'($urandom);
            r = pix_t'($urandom);
        end
        else if (pick < 55)
        begin
            base = $urandom_range(185, 255);
            b = clamp_chan(base + $urandom_range(0, 70) - 35);
            g = clamp_chan(base + $urandom_range(0, 70) - 35);
            r = clamp_chan(base + $urandom_range(0, 70) - 35);
        end
        else if (pick < 65)
        begin
            b = pix_t'($urandom);
            g = b;
            r = b;
        end
        else if (pick < 80)
        begin
            v0 = $urandom_range(0, 255);
            v1 = $urandom_range(0, 255);
            case ($urandom_range(0, 2))
                0:
                begin
                    r = pix_t'(v0); g = pix_t'(v0); b = pix_t'(v1);
                end
                1:
                begin
                    r = pix_t'(v0); b = pix_t'(v0); g = pix_t'(v1);
                end
                default:
                begin
                    g = pix_t'(v0); b = pix_t'(v0); r = pix_t'(v1);
                end
            endcase
        end
        else
        begin
            d = $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(1, 255);
            mn = $urandom_range(0, 255 - d);
            mid = $urandom_range(mn, mn + d);
            v0 = mn;
            v1 = mid;
            v2 = mn + d;
            case ($urandom_range(0, 5))
                0:
                begin
                    r = pix_t'(v2); g = pix_t'(v1); b = pix_t'(v0);
                end
                1:
                begin
                    r = pix_t'(v2); g = pix_t'(v0); b = pix_t'(v1);
                end
                2:
                begin
                    g = pix_t'(v2); r = pix_t'(v1); b = pix_t'(v0);
                end
                3:
                begin
                    g = pix_t'(v2); r = pix_t'(v0); b = pix_t'(v1);
                end
                4:
                begin
                    b = pix_t'(v2); r = pix_t'(v1); g = pix_t'(v0);
                end
                default:
                begin
                    b = pix_t'(v2); r = pix_t'(v0); g = pix_t'(v1);
                end
            endcase
        end
    endtask

    // Offer one pixel word and hold it until the block takes it, then log
    // its expected color. Between bursts, drop valid for a random gap;
    // inside a burst the next word follows back to back.
    task automatic offer_pixel(pix_t b, pix_t g, pix_t r, logic known,
                               code_t code);
        int    gap;
        code_t exp_code;
        pix_bus.valid <= 1'b1;
        pix_bus.blue  <= b;
        pix_bus.green <= g;
        pix_bus.red   <= r;
        @(posedge clk);
        while (!pix_bus.ready)
            @(posedge clk);
        exp_code = known ? code : sticker_color(b, g, r);
        color_queue = {color_queue, exp_code};
        if (no_gap)
            return;
        if (burst_left <= 0)
        begin
            // Now and then run a long stretch with no idling at all
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = 60;
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(0, 7);
            end
            if (gap > 0)
            begin
                pix_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold the sender until every expected color has come back
    task automatic wait_drained();
        while (color_queue.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: switch between stall patterns at random and honor a long
    // hold-off on request, counting it down here.
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       hold_left;
        int       beat;
        code_bus.ready <= 1'b0;
        mode = RX_FULL;
        mode_left = 0;
        hold_left = 0;
        beat = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            beat++;
            if (hold_req && hold_left == 0)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                code_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 64);
                end
                mode_left--;
                case (mode)
                    RX_FULL:   code_bus.ready <= 1'b1;
                    RX_COIN:   code_bus.ready <= $urandom_range(0, 1);
                    RX_SPARSE: code_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:   code_bus.ready <= (beat % 3 != 0);
                endcase
            end
        end
    end

    // Check every accepted color word against the oldest expectation
    always @(posedge clk)
    begin
        code_t want;
        if (rst_n && code_bus.valid && code_bus.ready)
        begin
            if (color_queue.size() == 0)
            begin
                $error("color_code: unexpected word, actual %0d", code_bus.color_code);
                fail_count++;
            end
            else
            begin
                want = color_queue.pop_front();
                if (code_bus.color_code !== want)
                begin
                    $error("color_code: expected %0d, actual %0d",
                           want, code_bus.color_code);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, pressure phases, random words
    initial
    begin
        pix_t b;
        pix_t g;
        pix_t r;
        fail_count = 0;
        hold_req = 1'b0;
        no_gap = 1'b0;
        burst_left = 0;
        rst_n <= 1'b0;
        pix_bus.valid <= 1'b0;
        pix_bus.blue  <= '0;
        pix_bus.green <= '0;
        pix_bus.red   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            offer_pixel(dir_rows[i].blue, dir_rows[i].green, dir_rows[i].red,
                        dir_rows[i].known, dir_rows[i].code);

        // Pause the sender until the pipeline is empty
        pix_bus.valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // Long receiver hold-off while the sender keeps offering back to
        // back, so the pipeline fills and stalls the pixel side
        hold_req = 1'b1;
        no_gap = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            draw_pixel(b, g, r);
            offer_pixel(b, g, r, 1'b0, ccc_pkg::CODE_WHITE);
        end
        no_gap = 1'b0;

        for (int i = 0; i < 1100; i++)
        begin
            draw_pixel(b, g, r);
            offer_pixel(b, g, r, 1'b0, ccc_pkg::CODE_WHITE);
            if (i == 550)
            begin
                pix_bus.valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
        end
        pix_bus.valid <= 1'b0;

        // Let the last words drain before the final check
        wait_drained();
        repeat (40) @(posedge clk);

        if (fail_count == 0 && color_queue.size() == 0)
            $display("PASS classify_cube_color");
        else
            $display("FAIL classify_cube_color");
        $finish;
    end

endmodule
